// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by bctb_back
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: %m");

`define ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_IMPL(label, cond, prop)

`define ASSERT_NEXT(label, cond, prop)

`endif

`endif

// ----- rtl/bctb_pkg.sv -----
// types, constants, rounding and saturation helpers for the box corner transform
// no dependencies
`default_nettype none

package bctb_pkg;

    localparam int W_W    = 32;
    localparam int S_W    = 16;
    localparam int Q_W    = 16;
    localparam int V_W    = 40;
    localparam int T_W    = 44;
    localparam int AB_W   = 48;
    localparam int SUM_W  = 50;
    localparam int PS_W   = W_W + S_W;
    localparam int CP_W   = Q_W + V_W + 1;
    localparam int P2_W   = Q_W + T_W + 1;

    localparam int SCALE_SH = 8;
    localparam int T_SH     = 13;
    localparam int R_SH     = 14;

    localparam int CORNERS = 8;
    localparam int CNT_W   = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int CFG_W  = 64;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] REG_QUAT    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SCALE_X = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SCALE_Y = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SCALE_Z = 3'd3;
    localparam logic [CIDX_W-1:0] REG_POS_X   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_POS_Y   = 3'd5;
    localparam logic [CIDX_W-1:0] REG_POS_Z   = 3'd6;

    localparam logic [CFG_W-1:0]      QUAT_RESET  = 64'h4000_0000_0000_0000;
    localparam logic signed [S_W-1:0] SCALE_RESET = 16'sd256;

    localparam logic signed [PS_W:0] HALF_V = (PS_W+1)'(2**(SCALE_SH-1));
    localparam logic signed [CP_W:0] HALF_T = (CP_W+1)'(2**(T_SH-1));
    localparam logic signed [P2_W:0] HALF_R = (P2_W+1)'(2**(R_SH-1));

    typedef struct packed {
        logic signed [W_W-1:0] point_x;
        logic signed [W_W-1:0] point_y;
        logic signed [W_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [W_W-1:0] world_x;
        logic signed [W_W-1:0] world_y;
        logic signed [W_W-1:0] world_z;
        logic signed [W_W-1:0] min_x;
        logic signed [W_W-1:0] min_y;
        logic signed [W_W-1:0] min_z;
        logic signed [W_W-1:0] max_x;
        logic signed [W_W-1:0] max_y;
        logic signed [W_W-1:0] max_z;
        logic                  last_corner;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0]      quat;
        logic signed [S_W-1:0] scale_x;
        logic signed [S_W-1:0] scale_y;
        logic signed [S_W-1:0] scale_z;
        logic signed [W_W-1:0] pos_x;
        logic signed [W_W-1:0] pos_y;
        logic signed [W_W-1:0] pos_z;
    } cfg_t;

    typedef struct packed {
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [V_W-1:0] vz;
        logic                  first;
        logic                  last;
    } scaled_t;

    // round half up, then floor
    function automatic logic signed [V_W-1:0] round_v(input logic signed [PS_W-1:0] x);
        logic signed [PS_W:0] y;
        y = $signed({x[PS_W-1], x}) + HALF_V;
        return V_W'(y >>> SCALE_SH);
    endfunction

    function automatic logic signed [T_W-1:0] round_t(input logic signed [CP_W-1:0] x);
        logic signed [CP_W:0] y;
        y = $signed({x[CP_W-1], x}) + HALF_T;
        return T_W'(y >>> T_SH);
    endfunction

    function automatic logic signed [AB_W-1:0] round_r(input logic signed [P2_W-1:0] x);
        logic signed [P2_W:0] y;
        y = $signed({x[P2_W-1], x}) + HALF_R;
        return AB_W'(y >>> R_SH);
    endfunction

    function automatic logic signed [W_W-1:0] sat_w(input logic signed [SUM_W-1:0] x);
        logic in_range;
        in_range = (&x[SUM_W-1:W_W-1]) || !(|x[SUM_W-1:W_W-1]);
        if (in_range)
        begin
            return x[W_W-1:0];
        end
        else if (x[SUM_W-1])
        begin
            return {1'b1, {(W_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(W_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bctb_front.sv -----
// front end: takes corner words, tags group position, applies per-axis scale
// depends on bctb_pkg
`default_nettype none

module bctb_front import bctb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire point_t  in_data,
    output logic         push,
    input  wire logic    q_ready,
    output scaled_t      push_data
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CORNERS - 1);

    logic             f_valid_reg;
    point_t           f_point_reg;
    logic             f_first_reg;
    logic             f_last_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_last;
    logic             accept;

    logic signed [PS_W-1:0] ps_x;
    logic signed [PS_W-1:0] ps_y;
    logic signed [PS_W-1:0] ps_z;

    assign push     = f_valid_reg && q_ready;
    assign in_ready = !f_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;

    assign is_last    = count_reg >= LAST_CNT;
    assign count_next = is_last ? '0 : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                f_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end
            else if (push)
            begin
                f_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_point_reg <= in_data;
            f_first_reg <= (count_reg == '0);
            f_last_reg  <= is_last;
        end
    end

    assign ps_x = f_point_reg.point_x * cfg.scale_x;
    assign ps_y = f_point_reg.point_y * cfg.scale_y;
    assign ps_z = f_point_reg.point_z * cfg.scale_z;

    always_comb
    begin
        push_data.vx    = round_v(ps_x);
        push_data.vy    = round_v(ps_y);
        push_data.vz    = round_v(ps_z);
        push_data.first = f_first_reg;
        push_data.last  = f_last_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/bctb_queue.sv -----
// two-entry queue between the front end and the transform back end
// depends on bctb_pkg
`default_nettype none

module bctb_queue import bctb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire scaled_t push_data,
    output logic         q_ready,
    output logic         q_valid,
    output scaled_t      q_data,
    input  wire logic    q_pop
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    scaled_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_ready = count_reg != FULL_CNT;
    assign q_valid = count_reg != '0;
    assign q_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bctb_back.sv -----
// back end: quaternion rotation, translation, saturation and running bounds
// depends on bctb_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bctb_back import bctb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    q_valid,
    input  wire scaled_t q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic adv;

    logic signed [Q_W-1:0] qw;
    logic signed [Q_W-1:0] qv [3];
    logic signed [V_W-1:0] hv [3];
    logic signed [W_W-1:0] pos [3];

    logic signed [T_W-1:0]  t_next  [3];
    logic signed [AB_W-1:0] a_next  [3];
    logic signed [AB_W-1:0] b_next  [3];
    logic signed [W_W-1:0]  w_next  [3];
    logic signed [W_W-1:0]  low_next  [3];
    logic signed [W_W-1:0]  high_next [3];

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic signed [V_W-1:0]  s1_v_reg [3];
    logic signed [T_W-1:0]  s1_t_reg [3];
    logic                   s1_first_reg;
    logic                   s1_last_reg;
    logic signed [V_W-1:0]  s2_v_reg [3];
    logic signed [AB_W-1:0] s2_a_reg [3];
    logic signed [AB_W-1:0] s2_b_reg [3];
    logic                   s2_first_reg;
    logic                   s2_last_reg;
    logic signed [W_W-1:0]  s3_w_reg [3];
    logic                   s3_first_reg;
    logic                   s3_last_reg;
    logic signed [W_W-1:0]  low_reg  [3];
    logic signed [W_W-1:0]  high_reg [3];
    result_t                out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign qw     = cfg.quat[63:48];
    assign qv[0]  = cfg.quat[47:32];
    assign qv[1]  = cfg.quat[31:16];
    assign qv[2]  = cfg.quat[15:0];
    assign hv[0]  = q_data.vx;
    assign hv[1]  = q_data.vy;
    assign hv[2]  = q_data.vz;
    assign pos[0] = cfg.pos_x;
    assign pos[1] = cfg.pos_y;
    assign pos[2] = cfg.pos_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        logic signed [CP_W-2:0]  m1;
        logic signed [CP_W-2:0]  m2;
        logic signed [CP_W-1:0]  dt;
        logic signed [P2_W-2:0]  pa;
        logic signed [P2_W-2:0]  pb1;
        logic signed [P2_W-2:0]  pb2;
        logic signed [P2_W-1:0]  db;
        logic signed [SUM_W-1:0] sum;
        logic signed [W_W-1:0]   w;

        // stage 1: t = 2 (q x v)
        assign m1        = qv[J] * hv[K];
        assign m2        = qv[K] * hv[J];
        assign dt        = $signed({m1[CP_W-2], m1}) - $signed({m2[CP_W-2], m2});
        assign t_next[i] = round_t(dt);

        // stage 2: w t and q x t
        assign pa        = qw * s1_t_reg[i];
        assign pb1       = qv[J] * s1_t_reg[K];
        assign pb2       = qv[K] * s1_t_reg[J];
        assign db        = $signed({pb1[P2_W-2], pb1}) - $signed({pb2[P2_W-2], pb2});
        assign a_next[i] = round_r($signed({pa[P2_W-2], pa}));
        assign b_next[i] = round_r(db);

        // stage 3: sum and saturate
        assign sum = $signed({{(SUM_W-V_W){s2_v_reg[i][V_W-1]}}, s2_v_reg[i]})
                   + $signed({{(SUM_W-AB_W){s2_a_reg[i][AB_W-1]}}, s2_a_reg[i]})
                   + $signed({{(SUM_W-AB_W){s2_b_reg[i][AB_W-1]}}, s2_b_reg[i]})
                   + $signed({{(SUM_W-W_W){pos[i][W_W-1]}}, pos[i]});
        assign w_next[i] = sat_w(sum);

        // bounds, seeded by the first corner of a group
        assign w            = s3_w_reg[i];
        assign low_next[i]  = (s3_first_reg || (w < low_reg[i]))  ? w : low_reg[i];
        assign high_next[i] = (s3_first_reg || (w > high_reg[i])) ? w : high_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_v_reg[i] <= hv[i];
                s1_t_reg[i] <= t_next[i];
                s2_v_reg[i] <= s1_v_reg[i];
                s2_a_reg[i] <= a_next[i];
                s2_b_reg[i] <= b_next[i];
                s3_w_reg[i] <= w_next[i];
            end
            s1_first_reg <= q_data.first;
            s1_last_reg  <= q_data.last;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
            if (s3_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    low_reg[i]  <= low_next[i];
                    high_reg[i] <= high_next[i];
                end
                out_data_reg.world_x     <= s3_w_reg[0];
                out_data_reg.world_y     <= s3_w_reg[1];
                out_data_reg.world_z     <= s3_w_reg[2];
                out_data_reg.min_x       <= low_next[0];
                out_data_reg.min_y       <= low_next[1];
                out_data_reg.min_z       <= low_next[2];
                out_data_reg.max_x       <= high_next[0];
                out_data_reg.max_y       <= high_next[1];
                out_data_reg.max_z       <= high_next[2];
                out_data_reg.last_corner <= s3_last_reg;
            end
        end
    end

    `ASSERT_IMPL(a_bounds_hold_world, out_valid_reg,
        (out_data_reg.min_x <= out_data_reg.world_x) &&
        (out_data_reg.world_x <= out_data_reg.max_x) &&
        (out_data_reg.min_y <= out_data_reg.world_y) &&
        (out_data_reg.world_y <= out_data_reg.max_y) &&
        (out_data_reg.min_z <= out_data_reg.world_z) &&
        (out_data_reg.world_z <= out_data_reg.max_z))
    `ASSERT_NEXT(a_first_seeds, adv && s3_valid_reg && s3_first_reg,
        (low_reg[0] == high_reg[0]) && (low_reg[1] == high_reg[1]) &&
        (low_reg[2] == high_reg[2]))
    `ASSERT_NEXT(a_last_reaches_out, adv && s3_valid_reg && s3_last_reg,
        out_valid_reg && out_data_reg.last_corner)

endmodule

`default_nettype wire

// ----- rtl/box_corner_transform_bounds.sv -----
// top level: configuration registers, front end, queue and back end
// depends on bctb_pkg, bctb_front, bctb_queue, bctb_back
//
//   channel   signals                          word
//   cfg       cfg_we, cfg_index, cfg_data      register write, no handshake back
//   in        in_valid, in_ready, in_data      one local corner (point_t)
//   out       out_valid, out_ready, out_data   world corner plus bounds (result_t)
//
// one corner word per cycle sustained while out_ready stays high
// from input accept to out_valid a corner passes the front register, the scale
// multiply into the queue, two multiply stages, sum/saturate, bounds into the output register
// the output register stalls the back end; the two-entry queue lets the front keep accepting
// reset returns registers to identity transform and clears the group count and all valids
`default_nettype none

module box_corner_transform_bounds import bctb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire point_t            in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output result_t                out_data
);

    cfg_t    cfg_reg;
    logic    push;
    logic    q_ready;
    scaled_t push_data;
    logic    q_valid;
    scaled_t q_data;
    logic    q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quat    <= QUAT_RESET;
            cfg_reg.scale_x <= SCALE_RESET;
            cfg_reg.scale_y <= SCALE_RESET;
            cfg_reg.scale_z <= SCALE_RESET;
            cfg_reg.pos_x   <= '0;
            cfg_reg.pos_y   <= '0;
            cfg_reg.pos_z   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUAT:    cfg_reg.quat    <= cfg_data;
                REG_SCALE_X: cfg_reg.scale_x <= cfg_data[S_W-1:0];
                REG_SCALE_Y: cfg_reg.scale_y <= cfg_data[S_W-1:0];
                REG_SCALE_Z: cfg_reg.scale_z <= cfg_data[S_W-1:0];
                REG_POS_X:   cfg_reg.pos_x   <= cfg_data[W_W-1:0];
                REG_POS_Y:   cfg_reg.pos_y   <= cfg_data[W_W-1:0];
                REG_POS_Z:   cfg_reg.pos_z   <= cfg_data[W_W-1:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    bctb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .q_ready   (q_ready),
        .push_data (push_data)
    );

    bctb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    bctb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
